>>> rtl/pcstp_pkg.sv
// ----------------------------------------------------------------------------
// pcstp_pkg
// Shared types and constants of the PC-indexed stride prefetcher.
// ----------------------------------------------------------------------------
`default_nettype none

package pcstp_pkg;

   localparam int TABLE_INDEX_BITS = 6;
   localparam int CONF_BITS        = 8;
   localparam int NUM_ENTRIES      = 1 << TABLE_INDEX_BITS;

   localparam int ADDR_W     = 48;
   localparam int PC_W       = 48;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
   localparam int STRIDE_W   = PAGE_W + 1;
   localparam int THRESH_W   = 8;
   localparam int CMP_W      = (CONF_BITS > THRESH_W) ? CONF_BITS : THRESH_W;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CONF_BITS-1:0] CONF_MAX = {CONF_BITS{1'b1}};

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD_EN    = 1'd1;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd2;

   typedef logic [TABLE_INDEX_BITS-1:0] index_type;

   typedef struct packed {
      logic [PC_W-1:0]      tag;
      logic [PAGE_W-1:0]    last_page;
      logic [STRIDE_W-1:0]  stride;
      logic                 stride_known;
      logic [CONF_BITS-1:0] confidence;
   } entry_type;

   typedef struct packed {
      logic              issue;
      logic [PAGE_W-1:0] fwd_page;
      logic [PAGE_W-1:0] bwd_page;
   } train_result_type;

   typedef struct packed {
      logic [PAGE_W-1:0] prefetch_page;
      logic              is_backward;
      logic              last;
   } rsp_item_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

>>> rtl/pcstp_intf.sv
// ----------------------------------------------------------------------------
// pcstp_intf
// Valid/ready channels for access items and prefetch items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcstp_req_if;
   logic                      valid;
   logic                      ready;
   logic [pcstp_pkg::ADDR_W-1:0] access_address;
   logic [pcstp_pkg::PC_W-1:0]   access_pc;

   modport source (output valid, output access_address, output access_pc, input ready);
   modport sink   (input valid, input access_address, input access_pc, output ready);
endinterface

interface pcstp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pcstp_pkg::PAGE_W-1:0] prefetch_page;
   logic                         is_backward;
   logic                         last;

   modport source (output valid, output prefetch_page, output is_backward, output last,
                   input ready);
   modport sink   (input valid, input prefetch_page, input is_backward, input last,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/pc_stride_tlb_prefetcher_core.sv
// ----------------------------------------------------------------------------
// pc_stride_tlb_prefetcher_core
// PC-indexed stride prefetcher for translation accesses: trains a
// direct-mapped table per access and emits up to two prefetch pages.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   req_bus | in  | valid/ready        | access_address[47:0], access_pc[47:0]
//   rsp_bus | out | valid/ready        | prefetch_page[35:0], is_backward, last
//   csr_*   | in  | csr_write_enable   | csr_index[0], csr_write_data[7:0]
//
// The accept edge launches the table read; in the lookup state the entry is
// updated and written back. The write lands before the next read, so no
// forwarding is needed.
// Reset is synchronous; the table's valid bits clear at once, so no sweep.
// An access that prefetches waits in the lookup state until the two-deep
// output buffer is empty; accesses that prefetch nothing never wait.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_stride_tlb_prefetcher_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pcstp_req_if.sink                                req_bus,
   pcstp_rsp_if.source                              rsp_bus,
   input  wire logic                                csr_write_enable,
   input  wire logic [pcstp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pcstp_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // Configuration registers
   logic [pcstp_pkg::THRESH_W-1:0] threshold_ff;
   logic                           backward_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= pcstp_pkg::THRESHOLD_RESET;
         backward_en_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pcstp_pkg::CSR_CONF_THRESHOLD: threshold_ff   <= csr_write_data;
            pcstp_pkg::CSR_BACKWARD_EN:    backward_en_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Control state
   pcstp_pkg::state_type state_ff, state_in;

   logic req_take;
   logic rsp_take;
   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   // Hold the accepted access for the lookup cycle
   logic [pcstp_pkg::PAGE_W-1:0] acc_page_ff;
   logic [pcstp_pkg::PC_W-1:0]   acc_pc_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         acc_page_ff <= req_bus.access_address[pcstp_pkg::ADDR_W-1:pcstp_pkg::PAGE_SHIFT];
         acc_pc_ff   <= req_bus.access_pc;
      end
   end

   // Table and training datapath
   pcstp_pkg::entry_type         rd_entry;
   pcstp_pkg::entry_type         new_entry;
   pcstp_pkg::train_result_type  train_res;
   logic                         tbl_wr_en;

   pcstp_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_take),
      .rd_index (req_bus.access_pc[pcstp_pkg::TABLE_INDEX_BITS-1:0]),
      .rd_entry (rd_entry),
      .wr_en    (tbl_wr_en),
      .wr_index (acc_pc_ff[pcstp_pkg::TABLE_INDEX_BITS-1:0]),
      .wr_entry (new_entry)
   );

   pcstp_train u_train (
      .cur_entry (rd_entry),
      .page      (acc_page_ff),
      .pc        (acc_pc_ff),
      .threshold (threshold_ff),
      .new_entry (new_entry),
      .result    (train_res)
   );

   // Output buffer: current item plus one pending backward item
   logic                     out_valid_ff, out_valid_in;
   pcstp_pkg::rsp_item_type  out_item_ff, out_item_in;
   logic                     bwd_pend_ff, bwd_pend_in;
   pcstp_pkg::rsp_item_type  bwd_item_ff, bwd_item_in;
   logic                     buf_free;

   assign buf_free = !out_valid_ff && !bwd_pend_ff;

   always_comb begin
      state_in     = state_ff;
      tbl_wr_en    = 1'b0;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      bwd_pend_in  = bwd_pend_ff;
      bwd_item_in  = bwd_item_ff;

      // Drain: advance the backward item or drop the last one
      if (rsp_take) begin
         if (bwd_pend_ff) begin
            out_item_in = bwd_item_ff;
            bwd_pend_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end

      case (state_ff)
         pcstp_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = pcstp_pkg::ST_LOOKUP;
            end
         end
         pcstp_pkg::ST_LOOKUP: begin
            // Commit once results can be loaded, or at once if there are none
            if (!train_res.issue || buf_free) begin
               tbl_wr_en = 1'b1;
               state_in  = pcstp_pkg::ST_IDLE;
               if (train_res.issue) begin
                  out_valid_in              = 1'b1;
                  out_item_in.prefetch_page = train_res.fwd_page;
                  out_item_in.is_backward   = 1'b0;
                  out_item_in.last          = !backward_en_ff;
                  bwd_pend_in               = backward_en_ff;
                  bwd_item_in.prefetch_page = train_res.bwd_page;
                  bwd_item_in.is_backward   = 1'b1;
                  bwd_item_in.last          = 1'b1;
               end
            end
         end
         default: begin
            state_in = pcstp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcstp_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         bwd_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         bwd_pend_ff  <= bwd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
      bwd_item_ff <= bwd_item_in;
   end

   assign req_bus.ready         = (state_ff == pcstp_pkg::ST_IDLE);
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.prefetch_page = out_item_ff.prefetch_page;
   assign rsp_bus.is_backward   = out_item_ff.is_backward;
   assign rsp_bus.last          = out_item_ff.last;

   // Checks
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == pcstp_pkg::ST_LOOKUP)
      else $error("accepted item did not enter lookup");

   a_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> state_ff == pcstp_pkg::ST_LOOKUP)
      else $error("table written outside lookup");

   a_bwd_behind_fwd: assert property (@(posedge clock) disable iff (reset)
      bwd_pend_ff |-> out_valid_ff && !out_item_ff.is_backward)
      else $error("backward item pending without forward item in front");

   a_not_last_has_more: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.last |-> bwd_pend_ff)
      else $error("non-final item with nothing behind it");

endmodule

`default_nettype wire

>>> rtl/pcstp_table.sv
// ----------------------------------------------------------------------------
// pcstp_table
// Direct-mapped entry memory, registered read, per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcstp_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire pcstp_pkg::index_type  rd_index,
   output pcstp_pkg::entry_type       rd_entry,
   input  wire logic                  wr_en,
   input  wire pcstp_pkg::index_type  wr_index,
   input  wire pcstp_pkg::entry_type  wr_entry
);

   pcstp_pkg::entry_type mem [pcstp_pkg::NUM_ENTRIES];

   logic [pcstp_pkg::NUM_ENTRIES-1:0] valid_ff;
   pcstp_pkg::entry_type              rd_data_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_index] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   // Entries never written read as the all-zero reset entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_index] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_index];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

>>> rtl/pcstp_train.sv
// ----------------------------------------------------------------------------
// pcstp_train
// Tag check, stride and confidence update, prefetch page generation.
// ----------------------------------------------------------------------------
`default_nettype none

module pcstp_train (
   input  wire pcstp_pkg::entry_type              cur_entry,
   input  wire logic [pcstp_pkg::PAGE_W-1:0]      page,
   input  wire logic [pcstp_pkg::PC_W-1:0]        pc,
   input  wire logic [pcstp_pkg::THRESH_W-1:0]    threshold,
   output pcstp_pkg::entry_type                   new_entry,
   output pcstp_pkg::train_result_type            result
);

   logic                              hit;
   logic [pcstp_pkg::STRIDE_W-1:0]    stride;
   logic [pcstp_pkg::CONF_BITS-1:0]   conf_up;

   assign hit     = (cur_entry.tag == pc);
   assign stride  = {1'b0, page} - {1'b0, cur_entry.last_page};
   assign conf_up = (cur_entry.confidence == pcstp_pkg::CONF_MAX) ?
                    pcstp_pkg::CONF_MAX : cur_entry.confidence + 1'b1;

   always_comb begin
      new_entry = cur_entry;
      new_entry.last_page = page;
      if (!hit) begin
         // reallocate
         new_entry.tag          = pc;
         new_entry.stride       = '0;
         new_entry.stride_known = 1'b0;
         new_entry.confidence   = '0;
      end else if (!cur_entry.stride_known) begin
         new_entry.stride       = stride;
         new_entry.stride_known = 1'b1;
         new_entry.confidence   = conf_up;
      end else if (cur_entry.stride == stride) begin
         new_entry.confidence   = conf_up;
      end else begin
         new_entry.stride       = stride;
         new_entry.confidence   = '0;
      end
   end

   assign result.issue = hit &&
      (pcstp_pkg::CMP_W'(new_entry.confidence) > pcstp_pkg::CMP_W'(threshold));
   assign result.fwd_page = page + new_entry.stride[pcstp_pkg::PAGE_W-1:0];
   assign result.bwd_page = page - new_entry.stride[pcstp_pkg::PAGE_W-1:0];

endmodule

`default_nettype wire
